FILE: rtl/core/fwcs_pkg.sv
// types and constants shared by the file write command sequencer
// no dependencies
package fwcs_pkg;

	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_RX      = 3'd1;
	localparam logic [2:0] REQ_START   = 3'd2;
	localparam logic [2:0] REQ_PATH    = 3'd3;
	localparam logic [2:0] REQ_PAYLOAD = 3'd4;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_GRANT  = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_CODE    = 2'd1;
	localparam logic [1:0] ERR_TIMEOUT = 2'd2;
	localparam logic [1:0] ERR_BADSTAT = 2'd3;

	localparam logic [7:0] FRAME_MARK  = 8'h2B;
	localparam logic [7:0] STATUS_MARK = 8'hA5;
	localparam logic [7:0] OP_OPEN     = 8'hC9;
	localparam logic [7:0] OP_WRITE    = 8'hCC;
	localparam logic [7:0] OP_CLOSE    = 8'hCE;
	localparam logic [7:0] OP_STATUS   = 8'h10;
	localparam logic [7:0] MODE_NEW    = 8'h0A;
	localparam logic [7:0] MODE_APPEND = 8'h32;

	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
	localparam int QUEUE_DEPTH = 4;

	// result sequences the back end expands
	typedef enum logic [3:0] {
		JOB_REJECT,
		JOB_FINISH,
		JOB_GRANT,
		JOB_OPEN,
		JOB_BYTE,
		JOB_BYTE_STAT,
		JOB_STAT,
		JOB_WRITE,
		JOB_CLOSE
	} job_op_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  data_byte;
		logic        overwrite;
		logic [31:0] total_size;
		logic [15:0] path_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [10:0] grant_length;
		logic [1:0]  error_kind;
		logic [7:0]  cartridge_code;
		logic        last;
	} out_item_t;

	typedef struct packed {
		job_op_t     op;
		logic [7:0]  data;
		logic [31:0] size;
		logic [10:0] grant;
		logic [1:0]  ek;
		logic [7:0]  code;
	} job_t;

	function automatic logic [7:0] frame_byte(input logic [7:0] op, input logic [1:0] k);
		logic [7:0] b;
		unique case (k)
			2'd0: b = FRAME_MARK;
			2'd1: b = ~FRAME_MARK;
			2'd2: b = op;
			default: b = ~op;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/core/fwcs_front.sv
// front end: accepts items, runs the write phase machine, issues jobs
// depends on fwcs_pkg
module fwcs_front import fwcs_pkg::*; #(
	parameter int MAX_BLOCK = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  in_item_t    in_item,
	input  logic        q_full,
	input  logic [15:0] timeout,
	output logic        accept,
	output logic        job_push,
	output job_t        job
);

	localparam int BLK_CAP = (MAX_BLOCK > 2047) ? 2047 : ((MAX_BLOCK < 1) ? 1 : MAX_BLOCK);

	typedef enum logic [7:0] {
		PH_IDLE       = 8'b0000_0001,
		PH_PATH       = 8'b0000_0010,
		PH_OPEN_PEND  = 8'b0000_0100,
		PH_OPEN_WAIT  = 8'b0000_1000,
		PH_GRANT_WAIT = 8'b0001_0000,
		PH_PAYLOAD    = 8'b0010_0000,
		PH_WSTAT_WAIT = 8'b0100_0000,
		PH_CLOSE_WAIT = 8'b1000_0000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] silence_q, silence_d;
	logic [31:0] size_q, size_d;
	logic [31:0] bytes_q, bytes_d;
	logic [10:0] block_q, block_d;
	logic [15:0] path_q, path_d;
	logic        reply_q, reply_d;
	logic [7:0]  first_q, first_d;
	logic [1:0]  hek_q, hek_d;
	logic [7:0]  hcd_q, hcd_d;

	logic        waiting;
	logic        hold_en;
	logic [1:0]  hold_ek;
	logic [7:0]  hold_cd;
	logic [1:0]  st_ek;
	logic [7:0]  st_cd;
	logic [15:0] path_dec;
	logic [10:0] block_dec;
	logic [31:0] bytes_dec;

	assign accept = in_valid && !q_full;
	assign waiting = (phase_q == PH_OPEN_WAIT) || (phase_q == PH_GRANT_WAIT) ||
		(phase_q == PH_WSTAT_WAIT) || (phase_q == PH_CLOSE_WAIT);
	assign path_dec  = path_q - 16'd1;
	assign block_dec = block_q - 11'd1;
	assign bytes_dec = bytes_q - 32'd1;

	always_comb begin
		phase_d   = phase_q;
		silence_d = silence_q;
		size_d    = size_q;
		bytes_d   = bytes_q;
		block_d   = block_q;
		path_d    = path_q;
		reply_d   = reply_q;
		first_d   = first_q;
		hek_d     = hek_q;
		hcd_d     = hcd_q;
		hold_en   = 1'b0;
		hold_ek   = ERR_OK;
		hold_cd   = '0;
		st_ek     = ERR_OK;
		st_cd     = '0;
		job_push  = 1'b0;
		job       = '{op: JOB_REJECT, data: '0, size: '0, grant: '0, ek: ERR_OK, code: '0};

		priority if (in_item.req_type == REQ_TICK) begin
			if (phase_q == PH_OPEN_PEND) begin
				job_push  = 1'b1;
				job.op    = JOB_STAT;
				phase_d   = PH_OPEN_WAIT;
				silence_d = '0;
				reply_d   = 1'b0;
			end else if (waiting) begin
				if (silence_q >= timeout) begin
					job_push = 1'b1;
					if (phase_q == PH_OPEN_WAIT) begin
						job.op  = JOB_FINISH;
						job.ek  = ERR_TIMEOUT;
						phase_d = PH_IDLE;
					end else if (phase_q == PH_CLOSE_WAIT) begin
						job.op  = JOB_FINISH;
						job.ek  = (hek_q != ERR_OK) ? hek_q : ERR_TIMEOUT;
						job.code = (hek_q != ERR_OK) ? hcd_q : 8'd0;
						phase_d = PH_IDLE;
					end else begin
						hold_en   = 1'b1;
						hold_ek   = ERR_TIMEOUT;
						job.op    = JOB_CLOSE;
						phase_d   = PH_CLOSE_WAIT;
						silence_d = '0;
						reply_d   = 1'b0;
					end
				end else begin
					silence_d = silence_q + 16'd1;
				end
			end
		end else if (in_item.req_type == REQ_RX && waiting) begin
			silence_d = '0;
			if (phase_q == PH_GRANT_WAIT) begin
				job_push = 1'b1;
				if (in_item.data_byte != 8'd0) begin
					hold_en  = 1'b1;
					hold_ek  = ERR_CODE;
					hold_cd  = in_item.data_byte;
					job.op   = JOB_CLOSE;
					phase_d  = PH_CLOSE_WAIT;
					reply_d  = 1'b0;
				end else begin
					job.op    = JOB_GRANT;
					job.grant = (bytes_q > 32'(BLK_CAP)) ? 11'(BLK_CAP) : bytes_q[10:0];
					block_d   = job.grant;
					phase_d   = PH_PAYLOAD;
				end
			end else if (!reply_q) begin
				first_d = in_item.data_byte;
				reply_d = 1'b1;
			end else begin
				reply_d  = 1'b0;
				job_push = 1'b1;
				if (first_q != STATUS_MARK) begin
					st_ek = ERR_BADSTAT;
				end else if (in_item.data_byte != 8'd0) begin
					st_ek = ERR_CODE;
					st_cd = in_item.data_byte;
				end
				if (phase_q == PH_OPEN_WAIT) begin
					if (st_ek != ERR_OK) begin
						job.op   = JOB_FINISH;
						job.ek   = st_ek;
						job.code = st_cd;
						phase_d  = PH_IDLE;
					end else if (size_q != 32'd0) begin
						job.op    = JOB_WRITE;
						job.size  = size_q;
						bytes_d   = size_q;
						phase_d   = PH_GRANT_WAIT;
						silence_d = '0;
					end else begin
						job.op  = JOB_CLOSE;
						phase_d = PH_CLOSE_WAIT;
					end
				end else if (phase_q == PH_WSTAT_WAIT) begin
					hold_en = (st_ek != ERR_OK);
					hold_ek = st_ek;
					hold_cd = st_cd;
					job.op  = JOB_CLOSE;
					phase_d = PH_CLOSE_WAIT;
				end else begin
					job.op   = JOB_FINISH;
					job.ek   = (hek_q != ERR_OK) ? hek_q : st_ek;
					job.code = (hek_q != ERR_OK) ? hcd_q : st_cd;
					phase_d  = PH_IDLE;
				end
			end
		end else if (in_item.req_type == REQ_START && phase_q == PH_IDLE) begin
			job_push  = 1'b1;
			job.op    = JOB_OPEN;
			job.data  = in_item.overwrite ? MODE_NEW : MODE_APPEND;
			job.size  = {16'd0, in_item.path_length};
			size_d    = in_item.total_size;
			path_d    = in_item.path_length;
			hek_d     = ERR_OK;
			hcd_d     = '0;
			phase_d   = (in_item.path_length != 16'd0) ? PH_PATH : PH_OPEN_PEND;
		end else if (in_item.req_type == REQ_PATH && phase_q == PH_PATH) begin
			job_push = 1'b1;
			job.data = in_item.data_byte;
			path_d   = path_dec;
			if (path_dec == 16'd0) begin
				job.op    = JOB_BYTE_STAT;
				phase_d   = PH_OPEN_WAIT;
				silence_d = '0;
				reply_d   = 1'b0;
			end else begin
				job.op = JOB_BYTE;
			end
		end else if (in_item.req_type == REQ_PAYLOAD && phase_q == PH_PAYLOAD) begin
			job_push = 1'b1;
			job.data = in_item.data_byte;
			job.op   = JOB_BYTE;
			block_d  = block_dec;
			bytes_d  = bytes_dec;
			if (block_dec == 11'd0) begin
				silence_d = '0;
				reply_d   = 1'b0;
				if (bytes_dec == 32'd0) begin
					job.op  = JOB_BYTE_STAT;
					phase_d = PH_WSTAT_WAIT;
				end else begin
					phase_d = PH_GRANT_WAIT;
				end
			end
		end else begin
			job_push = 1'b1;
			job.op   = JOB_REJECT;
		end

		// first error seen wins
		if (hold_en && hek_q == ERR_OK) begin
			hek_d = hold_ek;
			hcd_d = hold_cd;
		end
		job_push = job_push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			silence_q <= '0;
			size_q    <= '0;
			bytes_q   <= '0;
			block_q   <= '0;
			path_q    <= '0;
			reply_q   <= 1'b0;
			first_q   <= '0;
			hek_q     <= ERR_OK;
			hcd_q     <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			silence_q <= silence_d;
			size_q    <= size_d;
			bytes_q   <= bytes_d;
			block_q   <= block_d;
			path_q    <= path_d;
			reply_q   <= reply_d;
			first_q   <= first_d;
			hek_q     <= hek_d;
			hcd_q     <= hcd_d;
		end
	end

endmodule

FILE: rtl/core/fwcs_queue.sv
// short job queue between front and back end
// depends on fwcs_pkg
module fwcs_queue import fwcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic empty,
	output job_t head
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   count_q;

	assign full  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

FILE: rtl/core/fwcs_back.sv
// back end: expands each job into result beats, one per cycle while the output is not stalled
// depends on fwcs_pkg
module fwcs_back import fwcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  job_t      head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic [2:0] idx_q;
	logic       load;
	logic       out_valid_q;
	out_item_t  out_q, beat;

	assign load      = !q_empty && (!out_valid_q || !out_stall);
	assign pop       = load && beat.last;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		beat = '{kind: KIND_TX, tx_byte: '0, grant_length: '0, error_kind: ERR_OK,
			cartridge_code: '0, last: 1'b0};
		unique case (head.op)
			JOB_REJECT: begin
				beat.kind = KIND_REJECT;
				beat.last = 1'b1;
			end
			JOB_FINISH: begin
				beat.kind           = KIND_FINISH;
				beat.error_kind     = head.ek;
				beat.cartridge_code = head.code;
				beat.last           = 1'b1;
			end
			JOB_GRANT: begin
				beat.kind         = KIND_GRANT;
				beat.grant_length = head.grant;
				beat.last         = 1'b1;
			end
			JOB_OPEN: begin
				// frame, mode, big-endian path length
				if (!idx_q[2]) beat.tx_byte = frame_byte(OP_OPEN, idx_q[1:0]);
				else if (idx_q[1:0] == 2'd0) beat.tx_byte = head.data;
				else if (idx_q[1:0] == 2'd1) beat.tx_byte = head.size[15:8];
				else beat.tx_byte = head.size[7:0];
				beat.last = (idx_q == 3'd6);
			end
			JOB_BYTE: begin
				beat.tx_byte = head.data;
				beat.last    = 1'b1;
			end
			JOB_BYTE_STAT: begin
				beat.tx_byte = (idx_q == 3'd0) ? head.data :
					frame_byte(OP_STATUS, 2'(idx_q - 3'd1));
				beat.last = (idx_q == 3'd4);
			end
			JOB_STAT: begin
				beat.tx_byte = frame_byte(OP_STATUS, idx_q[1:0]);
				beat.last    = (idx_q == 3'd3);
			end
			JOB_WRITE: begin
				if (!idx_q[2]) beat.tx_byte = frame_byte(OP_WRITE, idx_q[1:0]);
				else begin
					unique case (idx_q[1:0])
						2'd0: beat.tx_byte = head.size[31:24];
						2'd1: beat.tx_byte = head.size[23:16];
						2'd2: beat.tx_byte = head.size[15:8];
						default: beat.tx_byte = head.size[7:0];
					endcase
				end
				beat.last = (idx_q == 3'd7);
			end
			JOB_CLOSE: begin
				beat.tx_byte = idx_q[2] ? frame_byte(OP_STATUS, idx_q[1:0]) :
					frame_byte(OP_CLOSE, idx_q[1:0]);
				beat.last = (idx_q == 3'd7);
			end
			default: begin
				beat.kind = KIND_REJECT;
				beat.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= beat.last ? 3'd0 : idx_q + 3'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/file_write_command_sequencer.sv
// Drives one file write to a cartridge: each accepted item produces 0 to 8 result beats,
// delivered one per cycle while not stalled, from a registered output. Items are taken one
// per cycle while the four-entry job queue has room; command bursts (open, write header, close)
// drain at one beat per cycle while not stalled; unstalled, the sustained input rate is one
// item per cycle for path/payload bytes, lower during frames. Timeout register at byte address 0.
// depends on fwcs_pkg, fwcs_front, fwcs_queue, fwcs_back
module file_write_command_sequencer import fwcs_pkg::*; #(
	parameter int MAX_BLOCK = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        q_full, q_empty, pop, job_push, accept;
	logic [15:0] timeout_q;
	job_t        job, head;

	assign pready   = 1'b1;
	assign in_stall = q_full;
	assign prdata   = (paddr[2] == 1'b0) ? {16'd0, timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			timeout_q <= pwdata[15:0];
		end
	end

	fwcs_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.q_full   (q_full),
		.timeout  (timeout_q),
		.accept   (accept),
		.job_push (job_push),
		.job      (job)
	);

	fwcs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	fwcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(job_push && q_full && !pop))
		else $error("job pushed into full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_item.kind == KIND_FINISH || out_item.kind == KIND_REJECT))
		|-> out_item.last)
		else $error("finish or reject beat not marked last");

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> accept)
		else $error("job issued without an accepted item");

endmodule
